FILE: design/process_state_queue_manager_assert.svh
// Assertion macros shared by the process state queue manager RTL.
`ifndef PROCESS_STATE_QUEUE_MANAGER_ASSERT_SVH
`define PROCESS_STATE_QUEUE_MANAGER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define PSQM_ASSERT_ALWAYS(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define PSQM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/psqm_pkg.sv
// Package: types, codes and constants of the process state queue manager.
package psqm_pkg;

    localparam int MAX_PROCESSES_DEF = 16;
    localparam int ID_BITS_DEF       = 16;

    localparam int CMD_W    = 3;
    localparam int TID_W    = 16;
    localparam int STATUS_W = 4;
    localparam int PSTATE_W = 3;
    localparam int REAP_W   = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE,
        CMD_ADMIT,
        CMD_DISPATCH,
        CMD_YIELD,
        CMD_BLOCK,
        CMD_WAKE,
        CMD_FINISH,
        CMD_REAP
    } cmd_t;

    typedef enum logic [PSTATE_W-1:0] {
        PS_NEW,
        PS_READY,
        PS_RUNNING,
        PS_BLOCKED,
        PS_TERMINATED
    } pstate_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK,
        STAT_INVALID_ID,
        STAT_NOT_FOUND,
        STAT_WRONG_STATE,
        STAT_NONE_RUNNING,
        STAT_ALREADY_RUNNING,
        STAT_NONE_READY,
        STAT_TABLE_FULL,
        STAT_IDS_EXHAUSTED
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FREE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FIFO_RD,
        S_FIFO_USE,
        S_SLOT_RD,
        S_SLOT_UPD,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        status_t             status;
        logic [TID_W-1:0]    result_id;
        pstate_t             from_state;
        pstate_t             to_state;
        logic [REAP_W-1:0]   reaped_count;
    } res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

    typedef struct packed {
        logic id_hit;
        logic state_hit;
    } cmp_out_t;

endpackage

FILE: design/psqm_ifs.sv
// Command and response channel interfaces.
interface psqm_cmd_if
    import psqm_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [TID_W-1:0]   target_id;

    modport source (output valid, output command, output target_id, input ready);
    modport sink   (input valid, input command, input target_id, output ready);
endinterface

interface psqm_rsp_if
    import psqm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TID_W-1:0]    result_id;
    logic [PSTATE_W-1:0] from_state;
    logic [PSTATE_W-1:0] to_state;
    logic [REAP_W-1:0]   reaped_count;

    modport source (output valid, output status, output result_id, output from_state,
                    output to_state, output reaped_count, input ready);
    modport sink   (input valid, input status, input result_id, input from_state,
                    input to_state, input reaped_count, output ready);
endinterface

FILE: design/psqm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

FILE: design/psqm_cmp.sv
// Shared compare unit: matches one table entry against the key id and state.
module psqm_cmp
    import psqm_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
)(
    input  logic                entry_valid,
    input  logic [ID_BITS-1:0]  entry_id,
    input  pstate_t             entry_state,
    input  logic [TID_W-1:0]    key_id,
    input  pstate_t             key_state,
    output cmp_out_t            hit
);

    // compare at the sum of the two widths so no bits are lost
    logic [ID_BITS+TID_W-1:0] entry_ext;
    logic [ID_BITS+TID_W-1:0] key_ext;

    assign entry_ext = {{TID_W{1'b0}}, entry_id};
    assign key_ext   = {{ID_BITS{1'b0}}, key_id};

    assign hit.id_hit    = entry_valid && (entry_ext == key_ext);
    assign hit.state_hit = entry_valid && (entry_state == key_state);

endmodule

FILE: design/psqm_ctrl.sv
// Sequencer: slot table, ready queue and command execution.
`include "process_state_queue_manager_assert.svh"

module psqm_ctrl
    import psqm_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
    parameter int ID_BITS       = ID_BITS_DEF
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  cmd_t             command,
    input  logic [TID_W-1:0] target_id,
    input  logic             take,
    output seq_stat_t        stat,
    output res_t             res
);

    localparam int SLOT_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
    localparam int ENT_W  = ID_BITS + PSTATE_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_PROCESSES - 1);
    localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_PROCESSES);
    localparam logic [CNT_W:0]    MAX_SUM   = (CNT_W + 1)'(MAX_PROCESSES);

    seq_state_t               state_reg, state_next;
    cmd_t                     cmd_reg, cmd_next;
    logic [TID_W-1:0]         tid_reg, tid_next;
    logic [SLOT_W-1:0]        idx_reg, idx_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    res_t                     res_reg, res_next;
    logic [MAX_PROCESSES-1:0] valid_reg, valid_next;
    logic [SLOT_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     run_valid_reg, run_valid_next;
    logic [SLOT_W-1:0]        run_slot_reg, run_slot_next;
    logic [ID_BITS:0]         next_id_reg, next_id_next;

    logic                slot_wr_en;
    logic [SLOT_W-1:0]   slot_wr_addr;
    logic [ENT_W-1:0]    slot_wr_data;
    logic                slot_rd_en;
    logic [SLOT_W-1:0]   slot_rd_addr;
    logic [ENT_W-1:0]    slot_rd_data;
    logic                fifo_wr_en;
    logic [SLOT_W-1:0]   fifo_rd_data;
    logic                fifo_rd_en;

    logic [ID_BITS-1:0]       ent_id;
    pstate_t                  ent_state;
    logic [ID_BITS+TID_W-1:0] ent_id_ext;
    logic [ID_BITS+TID_W-1:0] new_id_ext;
    logic [CNT_W+REAP_W-1:0]  reap_ext;
    pstate_t                  need_state;
    pstate_t                  move_state;
    cmp_out_t                 cmp_hit;
    logic                     last_idx;

    logic                push_req;
    logic [SLOT_W-1:0]   push_slot;
    logic [CNT_W:0]      push_sum;
    logic [CNT_W:0]      push_pos;
    logic [SLOT_W-1:0]   head_inc;

    assign ent_id     = slot_rd_data[ENT_W-1:PSTATE_W];
    assign ent_state  = pstate_t'(slot_rd_data[PSTATE_W-1:0]);
    assign ent_id_ext = {{TID_W{1'b0}}, ent_id};
    assign new_id_ext = {{TID_W{1'b0}}, next_id_reg[ID_BITS-1:0]};
    assign last_idx   = (idx_reg == LAST_SLOT);

    assign need_state = (cmd_reg == CMD_REAP)  ? PS_TERMINATED :
                        (cmd_reg == CMD_ADMIT) ? PS_NEW : PS_BLOCKED;
    assign move_state = (cmd_reg == CMD_YIELD) ? PS_READY :
                        (cmd_reg == CMD_BLOCK) ? PS_BLOCKED : PS_TERMINATED;

    // tail of the circular ready queue
    assign push_sum = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
    assign push_pos = (push_sum >= MAX_SUM) ? (push_sum - MAX_SUM) : push_sum;
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;

    psqm_cmp #(
        .ID_BITS (ID_BITS)
    ) u_cmp (
        .entry_valid (valid_reg[idx_reg]),
        .entry_id    (ent_id),
        .entry_state (ent_state),
        .key_id      (tid_reg),
        .key_state   (need_state),
        .hit         (cmp_hit)
    );

    // slot table: {id, state} per slot
    psqm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_PROCESSES)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    // ready queue of slot numbers
    psqm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_PROCESSES)
    ) u_fifo_ram (
        .clk     (clk),
        .wr_en   (fifo_wr_en),
        .wr_addr (push_pos[SLOT_W-1:0]),
        .wr_data (push_slot),
        .rd_en   (fifo_rd_en),
        .rd_addr (head_reg),
        .rd_data (fifo_rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (command)
                        CMD_CREATE:
                            state_next = next_id_reg[ID_BITS] ? S_DONE : S_FREE;
                        CMD_ADMIT, CMD_WAKE:
                            state_next = (target_id == '0) ? S_DONE : S_SCAN_RD;
                        CMD_DISPATCH:
                            state_next = run_valid_reg      ? S_SLOT_RD :
                                         (count_reg == '0)  ? S_DONE : S_FIFO_RD;
                        CMD_YIELD, CMD_BLOCK, CMD_FINISH:
                            state_next = run_valid_reg ? S_SLOT_RD : S_DONE;
                        CMD_REAP:
                            state_next = S_SCAN_RD;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_FREE:
            begin
                if (!valid_reg[idx_reg] || last_idx)
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN_RD:
                state_next = S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                if ((cmd_reg != CMD_REAP && cmp_hit.id_hit) || last_idx)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_FIFO_RD:
                state_next = S_FIFO_USE;
            S_FIFO_USE:
                state_next = S_SLOT_RD;
            S_SLOT_RD:
                state_next = S_SLOT_UPD;
            S_SLOT_UPD:
                state_next = S_DONE;
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cmd_next       = cmd_reg;
        tid_next       = tid_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        valid_next     = valid_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        run_valid_next = run_valid_reg;
        run_slot_next  = run_slot_reg;
        next_id_next   = next_id_reg;
        slot_wr_en     = 1'b0;
        slot_wr_addr   = idx_reg;
        slot_wr_data   = slot_rd_data;
        slot_rd_en     = 1'b0;
        slot_rd_addr   = idx_reg;
        fifo_rd_en     = 1'b0;
        push_req       = 1'b0;
        push_slot      = idx_reg;
        reap_ext       = {{REAP_W{1'b0}}, cnt_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command;
                    tid_next = target_id;
                    idx_next = '0;
                    cnt_next = '0;
                    res_next = '0;
                    case (command)
                        CMD_CREATE:
                        begin
                            if (next_id_reg[ID_BITS])
                            begin
                                res_next.status = STAT_IDS_EXHAUSTED;
                            end
                        end
                        CMD_ADMIT, CMD_WAKE:
                        begin
                            if (target_id == '0)
                            begin
                                res_next.status = STAT_INVALID_ID;
                            end
                        end
                        CMD_DISPATCH:
                        begin
                            slot_next = run_slot_reg;
                            if (run_valid_reg)
                            begin
                                res_next.status = STAT_ALREADY_RUNNING;
                            end
                            else if (count_reg == '0)
                            begin
                                res_next.status = STAT_NONE_READY;
                            end
                        end
                        CMD_YIELD, CMD_BLOCK, CMD_FINISH:
                        begin
                            slot_next = run_slot_reg;
                            if (!run_valid_reg)
                            begin
                                res_next.status = STAT_NONE_RUNNING;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FREE:
            begin
                if (!valid_reg[idx_reg])
                begin
                    slot_wr_en           = 1'b1;
                    slot_wr_data         = {next_id_reg[ID_BITS-1:0], PS_NEW};
                    valid_next[idx_reg]  = 1'b1;
                    res_next.result_id   = new_id_ext[TID_W-1:0];
                    next_id_next         = next_id_reg + 1'b1;
                end
                else if (last_idx)
                begin
                    res_next.status = STAT_TABLE_FULL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SCAN_RD:
            begin
                slot_rd_en = 1'b1;
            end
            S_SCAN_CHK:
            begin
                if (cmd_reg == CMD_REAP)
                begin
                    if (cmp_hit.state_hit)
                    begin
                        valid_next[idx_reg] = 1'b0;
                        cnt_next            = cnt_reg + 1'b1;
                    end
                    reap_ext              = {{REAP_W{1'b0}}, cnt_next};
                    res_next.reaped_count = reap_ext[REAP_W-1:0];
                    if (!last_idx)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (cmp_hit.id_hit)
                begin
                    res_next.result_id = tid_reg;
                    if (!cmp_hit.state_hit)
                    begin
                        res_next.status     = STAT_WRONG_STATE;
                        res_next.from_state = ent_state;
                    end
                    else
                    begin
                        slot_wr_en          = 1'b1;
                        slot_wr_data        = {ent_id, PS_READY};
                        push_req            = 1'b1;
                        res_next.from_state = need_state;
                        res_next.to_state   = PS_READY;
                    end
                end
                else if (last_idx)
                begin
                    res_next.status = STAT_NOT_FOUND;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FIFO_RD:
            begin
                fifo_rd_en = 1'b1;
            end
            S_FIFO_USE:
            begin
                slot_next  = fifo_rd_data;
                head_next  = head_inc;
                count_next = count_reg - 1'b1;
            end
            S_SLOT_RD:
            begin
                slot_rd_en   = 1'b1;
                slot_rd_addr = slot_reg;
            end
            S_SLOT_UPD:
            begin
                res_next.result_id = ent_id_ext[TID_W-1:0];
                slot_wr_addr       = slot_reg;
                push_slot          = slot_reg;
                if (cmd_reg == CMD_DISPATCH)
                begin
                    // already-running error only reports the running id
                    if (!run_valid_reg)
                    begin
                        slot_wr_en          = 1'b1;
                        slot_wr_data        = {ent_id, PS_RUNNING};
                        run_valid_next      = 1'b1;
                        run_slot_next       = slot_reg;
                        res_next.from_state = PS_READY;
                        res_next.to_state   = PS_RUNNING;
                    end
                end
                else
                begin
                    slot_wr_en          = 1'b1;
                    slot_wr_data        = {ent_id, move_state};
                    run_valid_next      = 1'b0;
                    res_next.from_state = PS_RUNNING;
                    res_next.to_state   = move_state;
                    push_req            = (cmd_reg == CMD_YIELD);
                end
            end
            default:
            begin
            end
        endcase

        // queue push; a full queue drops it
        fifo_wr_en = push_req && (count_reg < MAX_CNT);
        if (fifo_wr_en)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_slot_reg  <= '0;
            next_id_reg   <= (ID_BITS + 1)'(1);
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            run_valid_reg <= run_valid_next;
            run_slot_reg  <= run_slot_next;
            next_id_reg   <= next_id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        tid_reg  <= tid_next;
        idx_reg  <= idx_next;
        slot_reg <= slot_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign res       = res_reg;

    `PSQM_ASSERT_ALWAYS(a_queue_bound, clk, rst_n, count_reg <= MAX_CNT, "ready queue over capacity")
    `PSQM_ASSERT_ALWAYS(a_running_live, clk, rst_n, !run_valid_reg || valid_reg[run_slot_reg], "running slot is not allocated")
    `PSQM_ASSERT_ALWAYS(a_next_id_nonzero, clk, rst_n, next_id_reg != '0, "next id wrapped to zero")
    `PSQM_ASSERT_NEXT(a_result_held, clk, rst_n, state_reg == S_DONE && !take, state_reg == S_DONE && $stable(res_reg), "finished result changed before hand-off")

endmodule

FILE: design/process_state_queue_manager.sv
// Top level: process state queue manager with output register.
//
//   channel | dir | fields
//   --------+-----+-----------------------------------------------------------
//   cmd     | in  | command, target_id
//   rsp     | out | status, result_id, from_state, to_state, reaped_count
//
// One command at a time; cmd.ready is high only while the sequencer is idle.
// Create walks the allocation bits one slot a cycle until it finds a free one.
// Admit, wake and reap scan the slot table RAM through its single read port,
// reading each slot in S_SCAN_RD and checking it in S_SCAN_CHK. A result waits in
// the output register while the next command is taken; rsp.ready low stalls the
// sequencer only once both hold a result. Reset clears the allocation bits and
// queue pointers; no clear pass.
module process_state_queue_manager
    import psqm_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
    parameter int ID_BITS       = ID_BITS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    psqm_cmd_if.sink   cmd,
    psqm_rsp_if.source rsp
);

    seq_stat_t stat;
    res_t      seq_res;
    logic      start;
    logic      take;
    logic      out_valid_reg;
    res_t      out_res_reg;

    assign cmd.ready = stat.idle;
    assign start     = cmd.valid && stat.idle;
    assign take      = stat.done && (!out_valid_reg || rsp.ready);

    psqm_ctrl #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .ID_BITS       (ID_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (cmd_t'(cmd.command)),
        .target_id (cmd.target_id),
        .take      (take),
        .stat      (stat),
        .res       (seq_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_res_reg <= seq_res;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_res_reg.status;
    assign rsp.result_id    = out_res_reg.result_id;
    assign rsp.from_state   = out_res_reg.from_state;
    assign rsp.to_state     = out_res_reg.to_state;
    assign rsp.reaped_count = out_res_reg.reaped_count;

endmodule

FILE: tb/sv/process_state_queue_manager_test.sv
// Process state queue manager testbench: directed table, random lifecycle traffic, table overrun.
module process_state_queue_manager_test;
    import psqm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS       = MAX_PROCESSES_DEF;
    localparam int ID_RANGE     = ID_BITS_DEF;
    localparam int MAX_ID       = (1 << ID_RANGE) - 1;
    localparam int SCRIPT_LEN   = 25;
    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        cmd_t             op;
        logic [TID_W-1:0] tid;
        bit               typed;
        res_t             want;
    } script_row_t;

    localparam res_t NOT_TYPED = '0;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    psqm_cmd_if cmd_if ();
    psqm_rsp_if rsp_if ();

    process_state_queue_manager #(
        .MAX_PROCESSES (NSLOTS),
        .ID_BITS       (ID_RANGE)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    always #5 clk = ~clk;

    // Predicted block state
    bit               slot_used [NSLOTS];
    logic [TID_W-1:0] slot_pid  [NSLOTS];
    pstate_t          slot_ps   [NSLOTS];
    int               ready_line [$];
    bit               run_valid = 1'b0;
    int               run_slot  = 0;
    int               id_next   = 1;

    res_t awaited_rsp [$];
    int   errors     = 0;
    int   items_sent = 0;
    int   rsp_seen   = 0;
    int   burst_left = 0;

    function automatic res_t outcome(status_t st, logic [TID_W-1:0] id, pstate_t fs,
                                     pstate_t ts, logic [REAP_W-1:0] n);
        res_t r;
        r.status       = st;
        r.result_id    = id;
        r.from_state   = fs;
        r.to_state     = ts;
        r.reaped_count = n;
        return r;
    endfunction

    function automatic res_t lifecycle_step(cmd_t op, logic [TID_W-1:0] tid);
        res_t    r;
        int      s;
        pstate_t need;
        r = '0;
        s = -1;
        case (op)
            CMD_CREATE:
            begin
                foreach (slot_used[i])
                    if (!slot_used[i] && s < 0)
                        s = i;
                // exhaustion wins over a full table
                if (id_next > MAX_ID)
                    r.status = STAT_IDS_EXHAUSTED;
                else if (s < 0)
                    r.status = STAT_TABLE_FULL;
                else
                begin
                    slot_used[s] = 1'b1;
                    slot_pid[s]  = TID_W'(id_next);
                    slot_ps[s]   = PS_NEW;
                    r.result_id  = TID_W'(id_next);
                    id_next++;
                end
            end
            CMD_ADMIT, CMD_WAKE:
            begin
                need = PS_NEW;
                if (op == CMD_WAKE)
                    need = PS_BLOCKED;
                foreach (slot_used[i])
                    if (slot_used[i] && slot_pid[i] == tid && s < 0)
                        s = i;
                if (tid == '0)
                    r.status = STAT_INVALID_ID;
                else if (s < 0)
                    r.status = STAT_NOT_FOUND;
                else
                begin
                    r.result_id = tid;
                    if (slot_ps[s] != need)
                    begin
                        r.status     = STAT_WRONG_STATE;
                        r.from_state = slot_ps[s];
                    end
                    else
                    begin
                        r.from_state = need;
                        r.to_state   = PS_READY;
                        slot_ps[s]   = PS_READY;
                        if (ready_line.size() < NSLOTS)
                            ready_line.push_back(s);
                    end
                end
            end
            CMD_DISPATCH:
            begin
                if (run_valid)
                begin
                    r.status    = STAT_ALREADY_RUNNING;
                    r.result_id = slot_pid[run_slot];
                end
                else if (ready_line.size() == 0)
                    r.status = STAT_NONE_READY;
                else
                begin
                    s            = ready_line.pop_front();
                    slot_ps[s]   = PS_RUNNING;
                    run_valid    = 1'b1;
                    run_slot     = s;
                    r.result_id  = slot_pid[s];
                    r.from_state = PS_READY;
                    r.to_state   = PS_RUNNING;
                end
            end
            CMD_YIELD, CMD_BLOCK, CMD_FINISH:
            begin
                if (!run_valid)
                    r.status = STAT_NONE_RUNNING;
                else
                begin
                    if (op == CMD_YIELD)
                        r.to_state = PS_READY;
                    else if (op == CMD_BLOCK)
                        r.to_state = PS_BLOCKED;
                    else
                        r.to_state = PS_TERMINATED;
                    r.from_state      = PS_RUNNING;
                    r.result_id       = slot_pid[run_slot];
                    slot_ps[run_slot] = r.to_state;
                    run_valid         = 1'b0;
                    if (r.to_state == PS_READY && ready_line.size() < NSLOTS)
                        ready_line.push_back(run_slot);
                end
            end
            default:
            begin
                foreach (slot_used[i])
                    if (slot_used[i] && slot_ps[i] == PS_TERMINATED)
                    begin
                        slot_used[i] = 1'b0;
                        r.reaped_count++;
                    end
            end
        endcase
        return r;
    endfunction

    function automatic int free_slots();
        int n = 0;
        foreach (slot_used[i])
            if (!slot_used[i])
                n++;
        return n;
    endfunction

    // Random live slot in the given state (or in any state); -1 if none.
    function automatic int slot_in_state(pstate_t ps, bit any_state = 1'b0);
        int base;
        int s;
        base = $urandom_range(0, NSLOTS - 1);
        for (int k = 0; k < NSLOTS; k++)
        begin
            s = (base + k) % NSLOTS;
            if (slot_used[s] && (any_state || slot_ps[s] == ps))
                return s;
        end
        return -1;
    endfunction

    function automatic logic [TID_W-1:0] any_tid();
        return TID_W'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic issue(cmd_t op, logic [TID_W-1:0] tid, bit typed = 1'b0,
                         res_t want = '0);
        res_t predicted;
        cmd_if.valid     <= 1'b1;
        cmd_if.command   <= op;
        cmd_if.target_id <= tid;
        @(posedge clk);
        while (cmd_if.ready !== 1'b1)
            @(posedge clk);
        predicted = lifecycle_step(op, tid);
        awaited_rsp.push_back(typed ? want : predicted);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10))
                @(posedge clk);
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(30, 80);
            else
                burst_left = $urandom_range(0, 10);
        end
    endtask

    // Drive processes to terminated until quota are finished, then reap.
    task automatic retire(int quota);
        int finished;
        int s;
        finished = 0;
        while (finished < quota)
        begin
            if (run_valid)
            begin
                issue(CMD_FINISH, any_tid());
                finished++;
            end
            else if (ready_line.size() != 0)
                issue(CMD_DISPATCH, any_tid());
            else
            begin
                s = slot_in_state(PS_NEW);
                if (s >= 0)
                    issue(CMD_ADMIT, slot_pid[s]);
                else
                begin
                    s = slot_in_state(PS_BLOCKED);
                    if (s < 0)
                        break;
                    issue(CMD_WAKE, slot_pid[s]);
                end
            end
        end
        issue(CMD_REAP, any_tid());
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    task automatic take_result();
        res_t want;
        rsp_seen++;
        if (awaited_rsp.size() == 0)
        begin
            $error("result with nothing outstanding: status %0d id %0d",
                   rsp_if.status, rsp_if.result_id);
            errors++;
            return;
        end
        want = awaited_rsp.pop_front();
        check_field("status", 16'(want.status), 16'(rsp_if.status));
        check_field("result_id", want.result_id, rsp_if.result_id);
        check_field("from_state", 16'(want.from_state), 16'(rsp_if.from_state));
        check_field("to_state", 16'(want.to_state), 16'(rsp_if.to_state));
        check_field("reaped_count", 16'(want.reaped_count), 16'(rsp_if.reaped_count));
    endtask

    initial
    begin : cmd_side
        script_row_t      script [SCRIPT_LEN];
        int               roll;
        int               pick;
        int               n;
        int               s;
        bit               drained;
        cmd_t             op;
        pstate_t          need;
        logic [TID_W-1:0] tid;

        drained = 1'b0;
        cmd_if.valid     <= 1'b0;
        cmd_if.command   <= CMD_CREATE;
        cmd_if.target_id <= '0;

        script = '{
            '{CMD_DISPATCH, 16'h0000, 1'b1, outcome(STAT_NONE_READY, 0, PS_NEW, PS_NEW, 0)},
            '{CMD_YIELD, 16'h1234, 1'b1, outcome(STAT_NONE_RUNNING, 0, PS_NEW, PS_NEW, 0)},
            '{CMD_BLOCK, 16'h0000, 1'b1, outcome(STAT_NONE_RUNNING, 0, PS_NEW, PS_NEW, 0)},
            '{CMD_FINISH, 16'hFFFF, 1'b1, outcome(STAT_NONE_RUNNING, 0, PS_NEW, PS_NEW, 0)},
            '{CMD_REAP, 16'h0000, 1'b1, outcome(STAT_OK, 0, PS_NEW, PS_NEW, 0)},
            '{CMD_ADMIT, 16'h0000, 1'b1, outcome(STAT_INVALID_ID, 0, PS_NEW, PS_NEW, 0)},
            '{CMD_WAKE, 16'h0000, 1'b1, outcome(STAT_INVALID_ID, 0, PS_NEW, PS_NEW, 0)},
            '{CMD_ADMIT, 16'hFFFF, 1'b1, outcome(STAT_NOT_FOUND, 0, PS_NEW, PS_NEW, 0)},
            '{CMD_CREATE, 16'hFFFF, 1'b1, outcome(STAT_OK, 1, PS_NEW, PS_NEW, 0)},
            '{CMD_CREATE, 16'h0000, 1'b1, outcome(STAT_OK, 2, PS_NEW, PS_NEW, 0)},
            '{CMD_WAKE, 16'h0001, 1'b1, outcome(STAT_WRONG_STATE, 1, PS_NEW, PS_NEW, 0)},
            '{CMD_ADMIT, 16'h0001, 1'b1, outcome(STAT_OK, 1, PS_NEW, PS_READY, 0)},
            '{CMD_ADMIT, 16'h0001, 1'b1, outcome(STAT_WRONG_STATE, 1, PS_READY, PS_NEW, 0)},
            '{CMD_DISPATCH, 16'h0000, 1'b1, outcome(STAT_OK, 1, PS_READY, PS_RUNNING, 0)},
            '{CMD_DISPATCH, 16'h0000, 1'b1,
              outcome(STAT_ALREADY_RUNNING, 1, PS_NEW, PS_NEW, 0)},
            '{CMD_ADMIT, 16'h0002, 1'b0, NOT_TYPED},
            '{CMD_BLOCK, 16'h0000, 1'b0, NOT_TYPED},
            '{CMD_ADMIT, 16'h0001, 1'b1, outcome(STAT_WRONG_STATE, 1, PS_BLOCKED, PS_NEW, 0)},
            '{CMD_WAKE, 16'h0001, 1'b0, NOT_TYPED},
            '{CMD_DISPATCH, 16'h0000, 1'b0, NOT_TYPED},
            '{CMD_YIELD, 16'h0000, 1'b0, NOT_TYPED},
            '{CMD_DISPATCH, 16'h0000, 1'b0, NOT_TYPED},
            '{CMD_FINISH, 16'h0000, 1'b0, NOT_TYPED},
            '{CMD_REAP, 16'hFFFF, 1'b1, outcome(STAT_OK, 0, PS_NEW, PS_NEW, 1)},
            '{CMD_WAKE, 16'h0001, 1'b1, outcome(STAT_NOT_FOUND, 0, PS_NEW, PS_NEW, 0)}
        };

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            issue(script[i].op, script[i].tid, script[i].typed, script[i].want);

        while (items_sent < SCRIPT_LEN + RANDOM_ITEMS)
        begin
            if (!drained && items_sent >= SCRIPT_LEN + RANDOM_ITEMS / 2)
            begin
                cmd_if.valid <= 1'b0;
                while (awaited_rsp.size() != 0)
                    @(posedge clk);
                drained = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 6)
                issue(cmd_t'($urandom_range(0, 7)), any_tid());
            else if (roll < 7)
            begin
                // fill the table and overrun it by one
                n = free_slots() + 1;
                repeat (n)
                    issue(CMD_CREATE, any_tid());
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 10)
                    op = CMD_CREATE;
                else if (roll < 26)
                    op = CMD_ADMIT;
                else if (roll < 44)
                    op = CMD_DISPATCH;
                else if (roll < 54)
                    op = CMD_YIELD;
                else if (roll < 63)
                    op = CMD_BLOCK;
                else if (roll < 76)
                    op = CMD_WAKE;
                else if (roll < 89)
                    op = CMD_FINISH;
                else
                    op = CMD_REAP;
                tid = any_tid();
                if (op == CMD_ADMIT || op == CMD_WAKE)
                begin
                    need = PS_NEW;
                    if (op == CMD_WAKE)
                        need = PS_BLOCKED;
                    s    = slot_in_state(need);
                    pick = $urandom_range(0, 9);
                    if (pick < 7 && s >= 0)
                        tid = slot_pid[s];
                    else if (pick < 8)
                    begin
                        s = slot_in_state(need, 1'b1);
                        if (s >= 0)
                            tid = slot_pid[s];
                    end
                    else if (pick < 9)
                        tid = TID_W'($urandom_range(1, id_next + 4));
                    else if ($urandom_range(0, 1) == 0)
                        tid = '0;
                end
                issue(op, tid);
            end
        end

        // Retire everything, then fill the table and overrun it by one.
        retire(NSLOTS);
        n = free_slots() + 1;
        repeat (n)
            issue(CMD_CREATE, any_tid());
        retire(NSLOTS);

        cmd_if.valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (2 * NSLOTS + 8)
            @(posedge clk);
        if (errors == 0)
            $display("** process_state_queue_manager: PASSED **");
        else
            $display("** process_state_queue_manager: FAILED **");
        $finish;
    end

    initial
    begin : rsp_side
        int mode;
        int span_left;
        int hold_left;
        int holds_done;
        int tick;

        mode       = 0;
        span_left  = 0;
        hold_left  = 0;
        holds_done = 0;
        tick       = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
                take_result();
            // long hold-off so the block backs up onto its command input
            if (hold_left == 0 && holds_done < 2 && rsp_seen >= 500 * (holds_done + 1))
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                if (span_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    span_left = $urandom_range(10, 120);
                end
                span_left--;
                case (mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_if.ready <= (tick % 4 == 0);
                    default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        #(20_000_000);
        $display("** process_state_queue_manager: FAILED **");
        $finish;
    end

endmodule
